>>> hdl/tcw_pkg.sv
// shared constants, codes and types of the text console writer
package tcw_pkg;

  // screen geometry
  localparam int ROWS       = 25;
  localparam int COLS       = 80;
  localparam int CELLS      = ROWS * COLS;
  localparam int COPY_CELLS = (ROWS - 1) * COLS;

  // internal widths
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);

  // port field widths
  localparam int POS_W  = 11;
  localparam int OROW_W = 5;
  localparam int OCOL_W = 7;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int BYTE_W = 8;

  // cell and attribute constants
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;
  localparam logic [CELL_W-1:0] KEEP_BG    = 16'hF000;
  localparam logic [CELL_W-1:0] KEEP_FG    = 16'h0F00;

  // byte codes
  localparam logic [BYTE_W-1:0] CODE_BG_FG   = 8'h03;
  localparam logic [BYTE_W-1:0] CODE_FG      = 8'h04;
  localparam logic [BYTE_W-1:0] CODE_BG      = 8'h05;
  localparam logic [BYTE_W-1:0] CODE_NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ESC_IDLE       = 3'd0,
    ESC_FG         = 3'd1,
    ESC_BG         = 3'd2,
    ESC_BG_THEN_FG = 3'd3,
    ESC_FG_LAST    = 3'd4
  } esc_state_t;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_COPY,
    SW_DRAIN,
    SW_FILL
  } sweep_phase_t;

  typedef enum logic [2:0] {
    ST_BOOT,
    ST_BOOT_WAIT,
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } top_state_t;

  // request to the sweep unit
  typedef struct packed {
    logic go;
    logic scroll;
  } sweep_cmd_t;

  // one access to the screen store
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
  } ram_req_t;

  // put or clear request to the attribute unit
  typedef struct packed {
    logic              put;
    logic              clr;
    logic [BYTE_W-1:0] data;
    logic              end_call;
  } attr_req_t;

endpackage

>>> hdl/tcw_ram.sv
// generic single-clock ram with one write port and one registered read port
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/tcw_attr.sv
// color attribute register and escape decoder
module tcw_attr import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  attr_req_t         req,
  output logic [CELL_W-1:0] attr_cur,
  output logic [CELL_W-1:0] attr_nxt,
  output logic              text
);

  esc_state_t        esc_r, esc_nxt;
  logic [CELL_W-1:0] attr_r;
  logic [BYTE_W-1:0] digit;

  // hex digit value, raw byte for anything else
  function automatic logic [BYTE_W-1:0] digit_value(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = b;
    if (b >= "0" && b <= "9") begin
      v = b - 8'(48);
    end else if (b >= "a" && b <= "f") begin
      v = b - 8'(87);
    end else if (b >= "A" && b <= "F") begin
      v = b - 8'(55);
    end
    return v;
  endfunction

  assign digit    = digit_value(req.data);
  assign attr_cur = attr_r;

  // escape decode and attribute update
  always_comb begin
    esc_nxt  = esc_r;
    attr_nxt = attr_r;
    text     = 1'b0;
    if (req.clr) begin
      esc_nxt  = ESC_IDLE;
      attr_nxt = BLANK_CELL;
    end else if (req.put) begin
      unique case (esc_r)
        ESC_FG, ESC_FG_LAST: begin
          attr_nxt = (attr_r & KEEP_BG) + {digit, 8'h00};
          esc_nxt  = ESC_IDLE;
        end
        ESC_BG: begin
          attr_nxt = (attr_r & KEEP_FG) + {digit[3:0], 12'h000};
          esc_nxt  = ESC_IDLE;
        end
        ESC_BG_THEN_FG: begin
          attr_nxt = (attr_r & KEEP_FG) + {digit[3:0], 12'h000};
          esc_nxt  = ESC_FG_LAST;
        end
        default: begin
          if (req.data == CODE_BG_FG) begin
            esc_nxt = ESC_BG_THEN_FG;
          end else if (req.data == CODE_FG) begin
            esc_nxt = ESC_FG;
          end else if (req.data == CODE_BG) begin
            esc_nxt = ESC_BG;
          end else begin
            text = 1'b1;
          end
        end
      endcase
      if (req.end_call) begin
        esc_nxt = ESC_IDLE;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= ESC_IDLE;
      attr_r <= BLANK_CELL;
    end else begin
      esc_r  <= esc_nxt;
      attr_r <= attr_nxt;
    end
  end

  // the second escape digit only follows a combined code
  assert property (@(posedge clk) disable iff (!rst_n)
    esc_r == ESC_FG_LAST |-> $past(esc_r) == ESC_BG_THEN_FG || $past(esc_r) == ESC_FG_LAST)
    else $error("foreground-last state entered without combined code");

  // a clear always leaves the default attribute and an idle decoder
  assert property (@(posedge clk) disable iff (!rst_n)
    req.clr |=> attr_r == BLANK_CELL && esc_r == ESC_IDLE)
    else $error("clear did not restore attribute");

endmodule

>>> hdl/tcw_sweep.sv
// address sequencer that copies rows up for a scroll and fills cells with blanks
module tcw_sweep import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sweep_cmd_t        cmd,
  input  logic [CELL_W-1:0] rd_data,
  output ram_req_t          ram,
  output logic              done
);

  sweep_phase_t      phase_r, phase_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              cp_vld_r, cp_vld_nxt;
  logic [ADDR_W-1:0] cp_addr_r, cp_addr_nxt;

  // phase sequencing and store port drive
  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    cp_vld_nxt  = 1'b0;
    cp_addr_nxt = cp_addr_r;
    done        = 1'b0;
    ram.rd_en   = 1'b0;
    ram.rd_addr = idx_r + ADDR_W'(COLS);
    ram.wr_en   = 1'b0;
    ram.wr_addr = idx_r;
    ram.wr_data = BLANK_CELL;
    // copy write follows its read in the next cycle
    if (cp_vld_r) begin
      ram.wr_en   = 1'b1;
      ram.wr_addr = cp_addr_r;
      ram.wr_data = rd_data;
    end
    unique case (phase_r)
      SW_IDLE: begin
        if (cmd.go) begin
          idx_nxt   = '0;
          phase_nxt = cmd.scroll ? SW_COPY : SW_FILL;
        end
      end
      SW_COPY: begin
        ram.rd_en   = 1'b1;
        cp_vld_nxt  = 1'b1;
        cp_addr_nxt = idx_r;
        if (idx_r == ADDR_W'(COPY_CELLS - 1)) begin
          idx_nxt   = ADDR_W'(COPY_CELLS);
          phase_nxt = SW_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      SW_DRAIN: begin
        phase_nxt = SW_FILL;
      end
      SW_FILL: begin
        ram.wr_en   = 1'b1;
        ram.wr_addr = idx_r;
        ram.wr_data = BLANK_CELL;
        if (idx_r == ADDR_W'(CELLS - 1)) begin
          done      = 1'b1;
          phase_nxt = SW_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        phase_nxt = SW_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= SW_IDLE;
      cp_vld_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cp_vld_r <= cp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cp_addr_r <= cp_addr_nxt;
  end

  // writes stay inside the store
  assert property (@(posedge clk) disable iff (!rst_n)
    ram.wr_en |-> ram.wr_addr < ADDR_W'(CELLS))
    else $error("sweep write beyond store");

  // copy reads never reach past the last row
  assert property (@(posedge clk) disable iff (!rst_n)
    ram.rd_en |-> ram.rd_addr < ADDR_W'(CELLS))
    else $error("sweep read beyond store");

  // a pending copy write never collides with a fill write
  assert property (@(posedge clk) disable iff (!rst_n)
    cp_vld_r |-> phase_r != SW_FILL)
    else $error("copy write overlaps fill");

endmodule

>>> hdl/text_console_writer_core.sv
// text console writer top level: command sequencer, cursor and output registers
//
// Usage: drive start with one transaction (opcode, char_byte, end_of_call,
// cell_index) while busy is low; the transaction is taken at that clock edge.
// Exactly one result transaction follows, shown for a single cycle with
// out_valid high; the receiver cannot hold it off and must take it then.
// Path from the accepting edge to the cycle of out_valid:
//   put without scroll and unused opcode: straight into the result registers
//   read cell: registered store read, then the result registers
//   put that scrolls: copy of (ROWS-1)*COLS cells, a drain step, fill of COLS cells
//   clear screen: fill of ROWS*COLS cells, then the result registers
// The store has one write and one read port; the scroll copy moves one cell
// per cycle and the fill writes one cell per cycle.
// busy stays high until the result cycle, so one transaction is in work at a
// time; a new start may be accepted in the cycle out_valid is shown.
// Reset: cursor at 0, attribute 0x0700, escape decoder idle, and a clearing
// pass writes 0x0700 to every cell, with busy high throughout.
module text_console_writer_core import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [BYTE_W-1:0] in_char_byte,
  input  logic              in_end_of_call,
  input  logic [IDX_W-1:0]  in_cell_index,
  output logic              out_valid,
  output logic [POS_W-1:0]  out_cursor_pos,
  output logic [OROW_W-1:0] out_cursor_row,
  output logic [OCOL_W-1:0] out_cursor_col,
  output logic [CELL_W-1:0] out_cell_data,
  output logic [CELL_W-1:0] out_attribute,
  output logic              out_scrolled
);

  top_state_t        state_r, state_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;
  logic [OCOL_W-1:0] out_col_r, out_col_nxt;
  logic [CELL_W-1:0] out_cell_r, out_cell_nxt;
  logic [CELL_W-1:0] out_attr_r, out_attr_nxt;
  logic              out_scr_r, out_scr_nxt;

  logic              accept;
  opcode_t           op;
  logic              is_nl;
  logic              text;
  logic              text_put;
  logic              scroll;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [ADDR_W-1:0] cur_pos;
  logic [ADDR_W-1:0] nxt_pos;
  logic [CELL_W-1:0] attr_cur;
  logic [CELL_W-1:0] attr_nxt;

  attr_req_t         attr_req;
  sweep_cmd_t        sw_cmd;
  ram_req_t          sw_ram;
  ram_req_t          own_ram;
  ram_req_t          ram;
  logic              sw_done;
  logic [CELL_W-1:0] rd_data;

  assign busy   = state_r != ST_IDLE;
  assign accept = start && !busy;
  assign op     = opcode_t'(in_opcode);
  assign is_nl  = in_char_byte == CODE_NEWLINE;

  // attribute and escape unit
  assign attr_req.put      = accept && op == OP_PUT;
  assign attr_req.clr      = accept && op == OP_CLEAR;
  assign attr_req.data     = in_char_byte;
  assign attr_req.end_call = in_end_of_call;

  tcw_attr u_attr (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (attr_req),
    .attr_cur (attr_cur),
    .attr_nxt (attr_nxt),
    .text     (text)
  );

  // cursor advance, wrap and scroll detect
  assign text_put = attr_req.put && text;
  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign cur_pos  = ADDR_W'(row_r) * ADDR_W'(COLS) + ADDR_W'(col_r);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    scroll  = 1'b0;
    if (text_put) begin
      if (is_nl || col_inc >= (COL_W+1)'(COLS)) begin
        col_nxt = '0;
        if (row_inc >= (ROW_W+1)'(ROWS)) begin
          scroll  = 1'b1;
          row_nxt = ROW_W'(ROWS - 1);
        end else begin
          row_nxt = row_inc[ROW_W-1:0];
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  assign nxt_pos = ADDR_W'(row_nxt) * ADDR_W'(COLS) + ADDR_W'(col_nxt);

  // character write and cell read from the command side
  always_comb begin
    own_ram.wr_en   = text_put && !is_nl;
    own_ram.wr_addr = cur_pos;
    own_ram.wr_data = attr_cur | {8'h00, in_char_byte};
    own_ram.rd_en   = accept && op == OP_READ;
    own_ram.rd_addr = ADDR_W'(in_cell_index);
    if (in_cell_index >= IDX_W'(CELLS)) begin
      own_ram.rd_addr = '0;
    end
  end

  // sweep unit for scroll, clear and the reset pass
  tcw_sweep u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (sw_cmd),
    .rd_data (rd_data),
    .ram     (sw_ram),
    .done    (sw_done)
  );

  assign ram = (state_r == ST_SWEEP || state_r == ST_BOOT_WAIT) ? sw_ram : own_ram;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram.wr_en),
    .wr_addr (ram.wr_addr),
    .wr_data (ram.wr_data),
    .rd_en   (ram.rd_en),
    .rd_addr (ram.rd_addr),
    .rd_data (rd_data)
  );

  // command sequencer
  always_comb begin
    state_nxt     = state_r;
    sw_cmd.go     = 1'b0;
    sw_cmd.scroll = 1'b0;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_pos_nxt   = out_pos_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_cell_nxt  = out_cell_r;
    out_attr_nxt  = out_attr_r;
    out_scr_nxt   = out_scr_r;
    unique case (state_r)
      ST_BOOT: begin
        sw_cmd.go = 1'b1;
        state_nxt = ST_BOOT_WAIT;
      end
      ST_BOOT_WAIT: begin
        if (sw_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          out_pos_nxt  = POS_W'(nxt_pos);
          out_row_nxt  = OROW_W'(row_nxt);
          out_col_nxt  = OCOL_W'(col_nxt);
          out_cell_nxt = '0;
          out_attr_nxt = attr_nxt;
          out_scr_nxt  = scroll;
          rd_ok_nxt    = in_cell_index < IDX_W'(CELLS);
          unique case (op)
            OP_PUT: begin
              if (scroll) begin
                sw_cmd.go     = 1'b1;
                sw_cmd.scroll = 1'b1;
                state_nxt     = ST_SWEEP;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_READ: begin
              state_nxt = ST_READ;
            end
            OP_CLEAR: begin
              sw_cmd.go = 1'b1;
              state_nxt = ST_SWEEP;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_cell_nxt  = rd_ok_r ? rd_data : '0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SWEEP: begin
        if (sw_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BOOT;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    rd_ok_r    <= rd_ok_nxt;
    out_pos_r  <= out_pos_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_cell_r <= out_cell_nxt;
    out_attr_r <= out_attr_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cell_data  = out_cell_r;
  assign out_attribute  = out_attr_r;
  assign out_scrolled   = out_scr_r;

  // a result is only shown once the sequencer is back to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_IDLE)
    else $error("result shown while busy");

  // every accepted transaction either answers next cycle or keeps busy
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid || busy)
    else $error("accepted transaction dropped");

  // cursor stays on the screen
  assert property (@(posedge clk) disable iff (!rst_n)
    row_r < ROW_W'(ROWS) && col_r < COL_W'(COLS))
    else $error("cursor off screen");

  // a scroll leaves the cursor at the start of the last row
  assert property (@(posedge clk) disable iff (!rst_n)
    scroll |=> row_r == ROW_W'(ROWS - 1) && col_r == '0)
    else $error("scroll left cursor misplaced");

endmodule

>>> bench/tcw_checker.sv
// console status checker: shadow screen, predicted status per command, field compare
module tcw_checker import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [BYTE_W-1:0] in_char_byte,
  input  logic              in_end_of_call,
  input  logic [IDX_W-1:0]  in_cell_index,
  input  logic              out_valid,
  input  logic [POS_W-1:0]  out_cursor_pos,
  input  logic [OROW_W-1:0] out_cursor_row,
  input  logic [OCOL_W-1:0] out_cursor_col,
  input  logic [CELL_W-1:0] out_cell_data,
  input  logic [CELL_W-1:0] out_attribute,
  input  logic              out_scrolled,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                scrolls
);

  localparam int PRINT_LIMIT = 100;

  // one status transaction as the block reports it
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [OROW_W-1:0] row;
    logic [OCOL_W-1:0] col;
    logic [CELL_W-1:0] cell_val;
    logic [CELL_W-1:0] attr;
    logic              scrolled;
  } status_t;

  // shadow console state
  logic [CELL_W-1:0] shadow_cells [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [CELL_W-1:0] cur_attr;
  esc_state_t        esc;
  status_t           status_due [$];

  // print one line per mismatch, up to a cap, and count all of them
  task automatic report(input string what);
    if (errors < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [CELL_W-1:0] got_v,
                             input logic [CELL_W-1:0] want_v);
    if (got_v !== want_v)
      report($sformatf("%s is %0h, expected %0h", name, got_v, want_v));
  endtask

  task automatic blank_cells(input int unsigned first, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) shadow_cells[first + i] = BLANK_CELL;
  endtask

  // hex digit value, any other byte stands for itself
  function automatic logic [31:0] digit_of(input logic [BYTE_W-1:0] b);
    if (b >= "0" && b <= "9") return {24'h0, b - 8'h30};
    if (b >= "a" && b <= "f") return {24'h0, b - 8'h61} + 32'd10;
    if (b >= "A" && b <= "F") return {24'h0, b - 8'h41} + 32'd10;
    return {24'h0, b};
  endfunction

  // one put byte: escape decode, cell write, cursor advance, scroll
  task automatic put_byte(input logic [BYTE_W-1:0] b, output logic did_scroll);
    logic [31:0] digit;
    logic [31:0] sum;
    int unsigned at;
    did_scroll = 1'b0;
    if (esc != ESC_IDLE) begin
      digit = digit_of(b);
      if (esc == ESC_FG || esc == ESC_FG_LAST)
        sum = {16'h0, cur_attr & KEEP_BG} + (digit << 8);
      else
        sum = {16'h0, cur_attr & KEEP_FG} + (digit << 12);
      cur_attr = sum[CELL_W-1:0];
      esc = (esc == ESC_BG_THEN_FG) ? ESC_FG_LAST : ESC_IDLE;
    end else if (b == CODE_BG_FG) begin
      esc = ESC_BG_THEN_FG;
    end else if (b == CODE_FG) begin
      esc = ESC_FG;
    end else if (b == CODE_BG) begin
      esc = ESC_BG;
    end else begin
      if (b != CODE_NEWLINE) begin
        at = cur_row * COLS + cur_col;
        if (at < CELLS) shadow_cells[at] = cur_attr | {8'h00, b};
        cur_col++;
      end
      if (cur_col >= COLS || b == CODE_NEWLINE) begin
        cur_row++;
        cur_col = 0;
      end
      // scroll up one line and blank the bottom row
      if (cur_row >= ROWS) begin
        for (int i = 0; i < COPY_CELLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
        blank_cells(COPY_CELLS, COLS);
        cur_row = ROWS - 1;
        cur_col = 0;
        did_scroll = 1'b1;
      end
    end
  endtask

  // apply one command to the shadow and build the status it must report
  task automatic run_command(input opcode_t op, input logic [BYTE_W-1:0] b,
                             input logic eoc, input logic [IDX_W-1:0] idx,
                             output status_t st);
    logic        did_scroll;
    int unsigned pos;
    st = '0;
    did_scroll = 1'b0;
    case (op)
      OP_PUT: begin
        put_byte(b, did_scroll);
        if (eoc) esc = ESC_IDLE;
      end
      OP_READ: begin
        if (idx < CELLS) st.cell_val = shadow_cells[idx];
      end
      OP_CLEAR: begin
        cur_attr = BLANK_CELL;
        blank_cells(0, CELLS);
        esc = ESC_IDLE;
      end
      default: ;
    endcase
    pos = cur_row * COLS + cur_col;
    st.pos      = pos[POS_W-1:0];
    st.row      = cur_row[OROW_W-1:0];
    st.col      = cur_col[OCOL_W-1:0];
    st.attr     = cur_attr;
    st.scrolled = did_scroll;
  endtask

  // result first, then a command taken at the same edge
  always @(posedge clk) begin
    status_t want;
    status_t got;
    if (!rst_n) begin
      blank_cells(0, CELLS);
      cur_row  = 0;
      cur_col  = 0;
      cur_attr = BLANK_CELL;
      esc      = ESC_IDLE;
      status_due.delete();
      errors  = 0;
      checked = 0;
      scrolls = 0;
    end else begin
      if (out_valid) begin
        got = {out_cursor_pos, out_cursor_row, out_cursor_col, out_cell_data,
               out_attribute, out_scrolled};
        if (status_due.size() == 0) begin
          report("result transaction with no command outstanding");
        end else begin
          want = status_due.pop_front();
          check_field("cursor_pos", CELL_W'(got.pos), CELL_W'(want.pos));
          check_field("cursor_row", CELL_W'(got.row), CELL_W'(want.row));
          check_field("cursor_col", CELL_W'(got.col), CELL_W'(want.col));
          check_field("cell_data", got.cell_val, want.cell_val);
          check_field("attribute", got.attr, want.attr);
          check_field("scrolled", CELL_W'(got.scrolled), CELL_W'(want.scrolled));
          checked++;
          if (want.scrolled) scrolls++;
        end
      end
      if (start && !busy) begin
        run_command(opcode_t'(in_opcode), in_char_byte, in_end_of_call, in_cell_index, want);
        status_due.push_back(want);
      end
    end
    pending = status_due.size();
  end

endmodule

>>> bench/tb_top.sv
// testbench top: clock, reset, command stimulus, stall watchdog and verdict
module tb_top;
  import tcw_pkg::*;

  localparam int ITEMS       = 1650;
  localparam int MAX_GAP     = 13;
  localparam int STALL_LIMIT = 10000;
  localparam int TAIL_CYCLES = 2100;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic [BYTE_W-1:0] in_char_byte;
  logic              in_end_of_call;
  logic [IDX_W-1:0]  in_cell_index;
  logic              out_valid;
  logic [POS_W-1:0]  out_cursor_pos;
  logic [OROW_W-1:0] out_cursor_row;
  logic [OCOL_W-1:0] out_cursor_col;
  logic [CELL_W-1:0] out_cell_data;
  logic [CELL_W-1:0] out_attribute;
  logic              out_scrolled;

  int errors;
  int pending;
  int checked;
  int scrolls;
  int sent;
  int puts;
  int reads;
  int clears;
  int idle_cycles;
  bit no_gaps;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_console_writer_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_char_byte  (in_char_byte),
    .in_end_of_call(in_end_of_call),
    .in_cell_index (in_cell_index),
    .out_valid     (out_valid),
    .out_cursor_pos(out_cursor_pos),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .out_cell_data (out_cell_data),
    .out_attribute (out_attribute),
    .out_scrolled  (out_scrolled)
  );

  tcw_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_char_byte  (in_char_byte),
    .in_end_of_call(in_end_of_call),
    .in_cell_index (in_cell_index),
    .out_valid     (out_valid),
    .out_cursor_pos(out_cursor_pos),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .out_cell_data (out_cell_data),
    .out_attribute (out_attribute),
    .out_scrolled  (out_scrolled),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked),
    .scrolls       (scrolls)
  );

  // stall watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles at %0t", idle_cycles, $time);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // drive one command and return at the edge that takes it, start left high
  task automatic issue(input opcode_t op, input logic [BYTE_W-1:0] b, input logic eoc,
                       input logic [IDX_W-1:0] idx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_char_byte   <= b;
    in_end_of_call <= eoc;
    in_cell_index  <= idx;
    do @(negedge clk); while (busy);
    @(posedge clk);
    case (op)
      OP_PUT:   puts++;
      OP_READ:  reads++;
      OP_CLEAR: clears++;
      default: ;
    endcase
    if (op != OP_NONE) sent++;
  endtask

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
  endfunction

  // mostly printable text, some newlines, some arbitrary bytes
  function automatic logic [BYTE_W-1:0] text_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return CODE_NEWLINE;
    if (pick < 20) return BYTE_W'($urandom_range(0, 255));
    return BYTE_W'($urandom_range(8'h20, 8'h7E));
  endfunction

  // hex digit in either case, sometimes a raw byte
  function automatic logic [BYTE_W-1:0] color_digit();
    int pick;
    pick = $urandom_range(0, 23);
    if (pick < 10) return BYTE_W'("0" + pick);
    if (pick < 16) return BYTE_W'("a" + pick - 10);
    if (pick < 22) return BYTE_W'("A" + pick - 16);
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // color escape sequence; broken ones end the call on the code byte
  task automatic send_color(input bit broken);
    logic [BYTE_W-1:0] code;
    int                digits;
    case ($urandom_range(0, 2))
      0:       code = CODE_FG;
      1:       code = CODE_BG;
      default: code = CODE_BG_FG;
    endcase
    digits = (code == CODE_BG_FG) ? 2 : 1;
    issue(OP_PUT, code, broken, any_index());
    for (int i = 0; i < digits; i++)
      issue(OP_PUT, color_digit(), (i == digits - 1) && ($urandom_range(0, 3) == 0),
            any_index());
  endtask

  initial begin
    int pick;
    int run_len;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_opcode      <= OP_NONE;
    in_char_byte   <= '0;
    in_end_of_call <= 1'b0;
    in_cell_index  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: index extremes, byte extremes, every escape form, special cases
    issue(OP_READ, 8'h00, 1'b0, '0);
    issue(OP_READ, 8'hFF, 1'b1, IDX_W'(CELLS - 1));
    issue(OP_READ, 8'h00, 1'b0, IDX_W'(CELLS));
    issue(OP_READ, 8'h00, 1'b0, '1);
    issue(OP_PUT, "A", 1'b0, '0);
    issue(OP_PUT, 8'h00, 1'b0, '0);
    issue(OP_PUT, 8'hFF, 1'b0, '1);
    issue(OP_PUT, CODE_FG, 1'b0, '0);
    issue(OP_PUT, "3", 1'b1, '0);
    issue(OP_PUT, CODE_BG, 1'b0, '0);
    issue(OP_PUT, "c", 1'b0, '0);
    issue(OP_PUT, CODE_BG_FG, 1'b0, '0);
    issue(OP_PUT, "F", 1'b0, '0);
    issue(OP_PUT, "9", 1'b0, '0);
    // raw non-hex digits, attribute sum wraps past 16 bits
    issue(OP_PUT, CODE_FG, 1'b0, '0);
    issue(OP_PUT, 8'hFF, 1'b0, '0);
    issue(OP_PUT, CODE_BG, 1'b0, '0);
    issue(OP_PUT, 8'h80, 1'b0, '0);
    // end of call cancels a pending escape, so the next byte is printed
    issue(OP_PUT, CODE_FG, 1'b1, '0);
    issue(OP_PUT, "Z", 1'b0, '0);
    issue(OP_PUT, CODE_NEWLINE, 1'b0, '0);
    issue(OP_READ, 8'h00, 1'b0, IDX_W'(1));
    issue(OP_NONE, 8'h41, 1'b1, IDX_W'(5));
    issue(OP_CLEAR, 8'h00, 1'b0, '0);
    issue(OP_READ, 8'h00, 1'b0, IDX_W'(1));

    // random: text runs, color escapes, reads, the odd clear or unused opcode, newline bursts
    while (sent < ITEMS) begin
      if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        run_len = $urandom_range(1, 30);
        for (int i = 0; i < run_len; i++)
          issue(OP_PUT, text_byte(), (i == run_len - 1) && ($urandom_range(0, 1) == 1),
                any_index());
      end else if (pick < 70) begin
        send_color($urandom_range(0, 9) == 0);
      end else if (pick < 85) begin
        issue(OP_READ, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(CELLS, (1 << IDX_W) - 1))
                                          : IDX_W'($urandom_range(0, CELLS - 1)));
      end else if (pick < 88) begin
        issue(OP_CLEAR, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              any_index());
      end else if (pick < 90) begin
        issue(OP_NONE, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              any_index());
      end else begin
        run_len = $urandom_range(1, 8);
        for (int i = 0; i < run_len; i++)
          issue(OP_PUT, CODE_NEWLINE, 1'($urandom_range(0, 1)), any_index());
      end
    end
    start <= 1'b0;

    // drain outstanding results, then watch for strays
    do @(negedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d commands: %0d puts, %0d reads, %0d clears; %0d results checked",
             sent, puts, reads, clears, checked);
    $display("%0d puts scrolled the screen, %0d mismatches counted", scrolls, errors);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_attr.sv
hdl/tcw_sweep.sv
hdl/text_console_writer_core.sv
bench/tcw_checker.sv
bench/tb_top.sv
